// File: rtl/p3dmap_pkg.sv
// Shared types, constants and helpers for the pad3d source coordinate map.
// Depends on nothing; every rtl file imports it.
package p3dmap_pkg;

    localparam int CRD_W      = 10;   // output coordinate width
    localparam int EXT_W      = 9;    // extent register width
    localparam int SRC_W      = 8;    // source coordinate width
    localparam int PAD_W      = 8;    // leading pad width
    localparam int FILL_W     = 32;
    localparam int MODE_W     = 2;
    localparam int MAX_EXTENT = 256;

    localparam int MOD_STEPS  = 2;    // remainder steps per pipeline stage
    localparam int MOD_STG    = (CRD_W + MOD_STEPS - 1) / MOD_STEPS;
    // front stage, remainder stages, per-axis select stage, output stage
    localparam int NSTG       = MOD_STG + 3;

    localparam int DATA_W     = 32;
    localparam int REG_IDX_W  = 3;
    localparam int ADDR_W     = REG_IDX_W + 2;

    typedef enum logic [MODE_W-1:0] {
        PM_CONST   = 2'd0,
        PM_REFLECT = 2'd1,
        PM_REPL    = 2'd2,
        PM_CIRC    = 2'd3
    } t_pad_mode;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MODE   = 3'd0,
        REG_DEPTH  = 3'd1,
        REG_HEIGHT = 3'd2,
        REG_WIDTH  = 3'd3,
        REG_FRONT  = 3'd4,
        REG_TOP    = 3'd5,
        REG_LEFT   = 3'd6,
        REG_FILL   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [CRD_W-1:0] out_depth_index;
        logic [CRD_W-1:0] out_height_index;
        logic [CRD_W-1:0] out_width_index;
    } t_in;

    typedef struct packed {
        logic              is_fill;
        logic [SRC_W-1:0]  src_depth;
        logic [SRC_W-1:0]  src_height;
        logic [SRC_W-1:0]  src_width;
        logic [FILL_W-1:0] fill_word;
    } t_out;

    typedef struct packed {
        t_pad_mode         mode;
        logic [EXT_W-1:0]  ext_d;
        logic [EXT_W-1:0]  ext_h;
        logic [EXT_W-1:0]  ext_w;
        logic [PAD_W-1:0]  pad_d;
        logic [PAD_W-1:0]  pad_h;
        logic [PAD_W-1:0]  pad_w;
        logic [FILL_W-1:0] fill;
    } t_cfg;

    typedef struct packed {
        logic [NSTG-1:0] load;
    } t_pipe_ctl;

    // Saturate a raw extent into [1, MAX_EXTENT].
    function automatic logic [EXT_W-1:0] sat_extent(logic [EXT_W-1:0] e);
        logic [EXT_W-1:0] r;
        if (e == '0) begin
            r = EXT_W'(1);
        end else if (e > EXT_W'(MAX_EXTENT)) begin
            r = EXT_W'(MAX_EXTENT);
        end else begin
            r = e;
        end
        return r;
    endfunction

    // One restoring remainder step: subtract n << sh when it fits.
    function automatic logic [CRD_W-1:0] mod_step(logic [CRD_W-1:0] rem,
                                                  logic [EXT_W-1:0] n,
                                                  int unsigned      sh);
        logic [CRD_W+EXT_W-1:0] d;
        logic [CRD_W+EXT_W-1:0] r;
        d = {{CRD_W{1'b0}}, n} << sh;
        r = {{EXT_W{1'b0}}, rem};
        if (d <= r) begin
            r = r - d;
        end
        return r[CRD_W-1:0];
    endfunction

endpackage

// File: rtl/p3dmap_cfg.sv
// Configuration register file on an APB-style port, with extent saturation.
// Depends on p3dmap_pkg.
module p3dmap_cfg import p3dmap_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_pad_mode         r_mode;
    logic [EXT_W-1:0]  r_ext_d;
    logic [EXT_W-1:0]  r_ext_h;
    logic [EXT_W-1:0]  r_ext_w;
    logic [PAD_W-1:0]  r_pad_d;
    logic [PAD_W-1:0]  r_pad_h;
    logic [PAD_W-1:0]  r_pad_w;
    logic [FILL_W-1:0] r_fill;

    logic     wr_en;
    t_reg_idx idx;

    assign wr_en  = psel & penable & pwrite;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= PM_CONST;
            r_ext_d <= EXT_W'(1);
            r_ext_h <= EXT_W'(1);
            r_ext_w <= EXT_W'(1);
            r_pad_d <= '0;
            r_pad_h <= '0;
            r_pad_w <= '0;
            r_fill  <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_MODE:   r_mode  <= t_pad_mode'(pwdata[MODE_W-1:0]);
                REG_DEPTH:  r_ext_d <= pwdata[EXT_W-1:0];
                REG_HEIGHT: r_ext_h <= pwdata[EXT_W-1:0];
                REG_WIDTH:  r_ext_w <= pwdata[EXT_W-1:0];
                REG_FRONT:  r_pad_d <= pwdata[PAD_W-1:0];
                REG_TOP:    r_pad_h <= pwdata[PAD_W-1:0];
                REG_LEFT:   r_pad_w <= pwdata[PAD_W-1:0];
                REG_FILL:   r_fill  <= pwdata[FILL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MODE:   prdata = DATA_W'(r_mode);
            REG_DEPTH:  prdata = DATA_W'(r_ext_d);
            REG_HEIGHT: prdata = DATA_W'(r_ext_h);
            REG_WIDTH:  prdata = DATA_W'(r_ext_w);
            REG_FRONT:  prdata = DATA_W'(r_pad_d);
            REG_TOP:    prdata = DATA_W'(r_pad_h);
            REG_LEFT:   prdata = DATA_W'(r_pad_w);
            REG_FILL:   prdata = DATA_W'(r_fill);
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.mode  = r_mode;
        o_cfg.ext_d = sat_extent(r_ext_d);
        o_cfg.ext_h = sat_extent(r_ext_h);
        o_cfg.ext_w = sat_extent(r_ext_w);
        o_cfg.pad_d = r_pad_d;
        o_cfg.pad_h = r_pad_h;
        o_cfg.pad_w = r_pad_w;
        o_cfg.fill  = r_fill;
    end

endmodule

// File: rtl/p3dmap_ctl.sv
// Pipeline control: per-stage valid bits and backpressure with bubble removal.
// Depends on p3dmap_pkg.
module p3dmap_ctl import p3dmap_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_pipe_ctl o_pipe
);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] rdy;

    // A stage may load when it is empty or its contents move on.
    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        n_vld[0] = rdy[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_pipe.load = rdy;
    assign o_in_ready  = rdy[0];
    assign o_out_valid = r_vld[NSTG-1];

`ifndef SYNTHESIS
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_vld))
        else $error("input blocked while the pipeline has an empty stage");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted transaction missing from the front stage");

    a_drain_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && i_out_ready) |=> (!r_vld[NSTG-1] || $past(r_vld[NSTG-2])))
        else $error("output stage valid without a transaction behind it");
`endif

endmodule

// File: rtl/p3dmap_axis.sv
// Per-axis coordinate datapath: offset, reflect/clamp, pipelined remainder.
// Depends on p3dmap_pkg; stage loads come from p3dmap_ctl.
module p3dmap_axis import p3dmap_pkg::*; (
    input  logic             i_clk,
    input  t_pipe_ctl        i_pipe,
    input  logic [CRD_W-1:0] i_coord,
    input  logic [PAD_W-1:0] i_pad,
    input  logic [EXT_W-1:0] i_ext,
    input  t_pad_mode        i_mode,
    output logic [SRC_W-1:0] o_src,
    output logic             o_outside
);

    // stage 0 .. MOD_STG carry magnitude/remainder, sign and range flag
    logic [CRD_W-1:0] r_rem [MOD_STG+1];
    logic             r_neg [MOD_STG+1];
    logic             r_out [MOD_STG+1];
    logic [SRC_W-1:0] r_alt [1:MOD_STG];

    logic [SRC_W-1:0] r_src;
    logic             r_outside;

    logic [EXT_W-1:0]   n_m1;
    logic signed [CRD_W:0] s0_v;
    logic             s0_neg;
    logic [CRD_W-1:0] s0_mag;
    logic             s0_out;

    assign n_m1 = i_ext - EXT_W'(1);

    // Stage 0: signed offset from the leading pad, magnitude, range check.
    always_comb begin
        s0_v   = signed'({1'b0, i_coord}) - signed'({{(CRD_W+1-PAD_W){1'b0}}, i_pad});
        s0_neg = s0_v[CRD_W];
        s0_mag = s0_neg ? CRD_W'(-s0_v) : s0_v[CRD_W-1:0];
        s0_out = s0_neg || (s0_v[CRD_W-1:0] >= {{(CRD_W-EXT_W){1'b0}}, i_ext});
    end

    always_ff @(posedge i_clk) begin
        if (i_pipe.load[0]) begin
            r_rem[0] <= s0_mag;
            r_neg[0] <= s0_neg;
            r_out[0] <= s0_out;
        end
    end

    for (genvar s = 1; s <= MOD_STG; s++) begin : g_mod
        localparam int TOP_BIT = CRD_W - 1 - (s - 1) * MOD_STEPS;
        logic [CRD_W-1:0] n_rem;

        always_comb begin
            n_rem = r_rem[s-1];
            for (int j = 0; j < MOD_STEPS; j++) begin
                if (TOP_BIT - j >= 0) begin
                    n_rem = mod_step(n_rem, i_ext, unsigned'(TOP_BIT - j));
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_pipe.load[s]) begin
                r_rem[s] <= n_rem;
                r_neg[s] <= r_neg[s-1];
                r_out[s] <= r_out[s-1];
            end
        end

        if (s == 1) begin : g_alt
            logic signed [CRD_W+1:0] refl_a;
            logic signed [CRD_W+1:0] refl_m;
            logic signed [CRD_W+1:0] refl;
            logic [SRC_W-1:0]        refl_c;
            logic [SRC_W-1:0]        n_alt;

            // Mirror without repeating the edge, then clamp into the extent.
            always_comb begin
                refl_a = signed'({2'b00, r_rem[0]});
                refl_m = signed'({{(CRD_W+1-EXT_W){1'b0}}, n_m1, 1'b0}) - refl_a;
                refl   = (refl_m < refl_a) ? refl_m : refl_a;
                if (refl < 0) begin
                    refl_c = '0;
                end else if (refl > signed'({{(CRD_W+2-EXT_W){1'b0}}, n_m1})) begin
                    refl_c = SRC_W'(n_m1);
                end else begin
                    refl_c = refl[SRC_W-1:0];
                end

                case (i_mode)
                    PM_REFLECT: n_alt = refl_c;
                    PM_REPL: begin
                        if (r_neg[0]) begin
                            n_alt = '0;
                        end else if (r_out[0]) begin
                            n_alt = SRC_W'(n_m1);
                        end else begin
                            n_alt = r_rem[0][SRC_W-1:0];
                        end
                    end
                    default: n_alt = r_out[0] ? '0 : r_rem[0][SRC_W-1:0];
                endcase
            end

            always_ff @(posedge i_clk) begin
                if (i_pipe.load[s]) begin
                    r_alt[s] <= n_alt;
                end
            end
        end else begin : g_hold
            always_ff @(posedge i_clk) begin
                if (i_pipe.load[s]) begin
                    r_alt[s] <= r_alt[s-1];
                end
            end
        end
    end

    logic [EXT_W-1:0] circ_neg;
    logic [SRC_W-1:0] circ;
    logic [SRC_W-1:0] n_src;

    // True modulo: a negative offset with a nonzero remainder folds to n - rem.
    always_comb begin
        circ_neg = i_ext - r_rem[MOD_STG][EXT_W-1:0];
        if (r_neg[MOD_STG] && (r_rem[MOD_STG] != '0)) begin
            circ = SRC_W'(circ_neg);
        end else begin
            circ = r_rem[MOD_STG][SRC_W-1:0];
        end
        n_src = (i_mode == PM_CIRC) ? circ : r_alt[MOD_STG];
    end

    always_ff @(posedge i_clk) begin
        if (i_pipe.load[MOD_STG+1]) begin
            r_src     <= n_src;
            r_outside <= r_out[MOD_STG];
        end
    end

    assign o_src     = r_src;
    assign o_outside = r_outside;

endmodule

// File: rtl/pad3d_source_coordinate_map_top.sv
// Channel     | valid        | ready        | payload
// input       | i_in_valid   | o_in_ready   | i_in  (t_in)
// output      | o_out_valid  | i_out_ready  | o_out (t_out)
// config      | psel/penable | pready       | paddr, pwdata, prdata
//
// One transaction per cycle is accepted and delivered while i_out_ready stays high.
// The pipeline depth is set by the ten-step remainder for circular mode, two steps a stage.
// Synchronous active-low reset clears all valid bits and restores register defaults.
// Each stage holds under backpressure and empty stages fill, so input stays ready
// until every stage holds a transaction.
//
// Top level of the pad3d source coordinate map; depends on p3dmap_pkg,
// p3dmap_cfg, p3dmap_ctl and p3dmap_axis.
module pad3d_source_coordinate_map_top import p3dmap_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg      cfg;
    t_pipe_ctl pipe;

    logic [SRC_W-1:0] src_d;
    logic [SRC_W-1:0] src_h;
    logic [SRC_W-1:0] src_w;
    logic             out_d;
    logic             out_h;
    logic             out_w;

    t_out r_out;
    t_out n_out;

    p3dmap_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    p3dmap_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_pipe      (pipe)
    );

    p3dmap_axis u_axis_d (
        .i_clk     (i_clk),
        .i_pipe    (pipe),
        .i_coord   (i_in.out_depth_index),
        .i_pad     (cfg.pad_d),
        .i_ext     (cfg.ext_d),
        .i_mode    (cfg.mode),
        .o_src     (src_d),
        .o_outside (out_d)
    );

    p3dmap_axis u_axis_h (
        .i_clk     (i_clk),
        .i_pipe    (pipe),
        .i_coord   (i_in.out_height_index),
        .i_pad     (cfg.pad_h),
        .i_ext     (cfg.ext_h),
        .i_mode    (cfg.mode),
        .o_src     (src_h),
        .o_outside (out_h)
    );

    p3dmap_axis u_axis_w (
        .i_clk     (i_clk),
        .i_pipe    (pipe),
        .i_coord   (i_in.out_width_index),
        .i_pad     (cfg.pad_w),
        .i_ext     (cfg.ext_w),
        .i_mode    (cfg.mode),
        .o_src     (src_w),
        .o_outside (out_w)
    );

    // Fill only in constant mode; zero the coordinates of a fill point.
    always_comb begin
        n_out.is_fill = (cfg.mode == PM_CONST) && (out_d || out_h || out_w);
        if (n_out.is_fill) begin
            n_out.src_depth  = '0;
            n_out.src_height = '0;
            n_out.src_width  = '0;
            n_out.fill_word  = cfg.fill;
        end else begin
            n_out.src_depth  = src_d;
            n_out.src_height = src_h;
            n_out.src_width  = src_w;
            n_out.fill_word  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe.load[NSTG-1]) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule
